>>> rtl/core/rotation_matrix_to_euler_zyx_top_defines.svh
// Assertion macros for the Euler angle block
`ifndef ROTATION_MATRIX_TO_EULER_ZYX_TOP_DEFINES_SVH
`define ROTATION_MATRIX_TO_EULER_ZYX_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define EUL_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked outside reset
`define EUL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/core/eul_pkg.sv
package eul_pkg;

    localparam int SqrtSteps     = 16;
    localparam int CordicStepsDef = 16;
    localparam int XyW           = 34;
    localparam int ZW            = 28;
    localparam int OpW           = 18;
    localparam int PreShift      = 12;
    localparam logic signed [ZW-1:0] HalfPiQ24 = 28'sd26353589;
    localparam logic signed [16:0]   PiQ313    = 17'sd25736;

    // square root pipeline word
    typedef struct packed {
        logic        valid;
        logic [31:0] rem;
        logic [31:0] root;
        logic signed [15:0] m00;
        logic signed [15:0] m10;
        logic signed [15:0] m20;
        logic signed [15:0] m21;
        logic signed [15:0] m22;
        logic signed [15:0] m11;
        logic signed [15:0] m12;
    } sq_t;

    // CORDIC pipeline word
    typedef struct packed {
        logic                  valid;
        logic                  zero;
        logic                  tag;
        logic signed [XyW-1:0] x;
        logic signed [XyW-1:0] y;
        logic signed [ZW-1:0]  z;
    } cordic_t;

    // round(atan(2^-i) * 2^24)
    function automatic logic signed [ZW-1:0] atan_q24(input int i);
        logic signed [ZW-1:0] v;
        case (i)
            0:  v = 28'sd13176795;
            1:  v = 28'sd7778716;
            2:  v = 28'sd4110060;
            3:  v = 28'sd2086331;
            4:  v = 28'sd1047214;
            5:  v = 28'sd524117;
            6:  v = 28'sd262123;
            7:  v = 28'sd131069;
            8:  v = 28'sd65536;
            9:  v = 28'sd32768;
            10: v = 28'sd16384;
            11: v = 28'sd8192;
            12: v = 28'sd4096;
            13: v = 28'sd2048;
            14: v = 28'sd1024;
            15: v = 28'sd512;
            16: v = 28'sd256;
            17: v = 28'sd128;
            18: v = 28'sd64;
            19: v = 28'sd32;
            20: v = 28'sd16;
            21: v = 28'sd8;
            22: v = 28'sd4;
            23: v = 28'sd2;
            default: v = '0;
        endcase
        return v;
    endfunction

    // scale operands and fold the left half-plane onto the right
    function automatic cordic_t prerot(input logic vld, input logic tg,
                                       input logic signed [OpW-1:0] yi,
                                       input logic signed [OpW-1:0] xi);
        cordic_t c;
        logic signed [XyW-1:0] xs;
        logic signed [XyW-1:0] ys;
        xs = XyW'(xi) <<< PreShift;
        ys = XyW'(yi) <<< PreShift;
        c.valid = vld;
        c.tag   = tg;
        c.zero  = (xi == '0) && (yi == '0);
        if (xs[XyW-1] && !ys[XyW-1])
        begin
            c.x = ys;
            c.y = -xs;
            c.z = HalfPiQ24;
        end
        else if (xs[XyW-1])
        begin
            c.x = -ys;
            c.y = xs;
            c.z = -HalfPiQ24;
        end
        else
        begin
            c.x = xs;
            c.y = ys;
            c.z = '0;
        end
        return c;
    endfunction

    // Q24 angle to saturated Q3.13
    function automatic logic signed [15:0] to_q313(input cordic_t c);
        logic signed [ZW-1:0] rz;
        logic signed [16:0]   r;
        rz = (c.z + ZW'(1024)) >>> 11;
        r  = 17'(rz);
        if (c.zero)
            r = '0;
        else if (r > PiQ313)
            r = PiQ313;
        else if (r < -PiQ313)
            r = -PiQ313;
        return r[15:0];
    endfunction

endpackage

>>> rtl/core/rotation_matrix_to_euler_zyx_top.sv
// Channel  Dir  Width  Contents
// s_*      in   112    m00 m10 m20 m21 m22 m11 m12, 16 bits each, Q2.14
// m_*      out  48+1   roll pitch yaw (Q3.13), tuser is_singular
// cfg_*    in   15     singular_threshold write
//
// One matrix per cycle unless a held result stalls the row; stages: square stage,
// 16 square-root cells, operand select, CORDIC_STEPS rotation cells, output.
// All stages advance together; a held result on m_* stalls the whole row.
// rst_n clears valid flags and sets the threshold to 1.
module rotation_matrix_to_euler_zyx_top import eul_pkg::*; #(
    parameter int CORDIC_STEPS = CordicStepsDef
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [111:0] s_tdata,   // m00, m10, m20, m21, m22, m11, m12
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [47:0]  m_tdata,   // roll_angle, pitch_angle, yaw_angle
    output logic [0:0]   m_tuser,   // is_singular
    input  logic         cfg_wr_en,
    input  logic [14:0]  cfg_wr_data
);

`include "rotation_matrix_to_euler_zyx_top_defines.svh"

    logic        adv;
    logic [14:0] thr_reg;
    sq_t         sq_link [SqrtSteps+1];
    sq_t         sq_reg;
    sq_t         sq_next;
    cordic_t     roll_in_reg, pitch_in_reg, yaw_in_reg;
    cordic_t     roll_in_next, pitch_in_next, yaw_in_next;
    cordic_t     roll_out, pitch_out, yaw_out;
    logic        out_valid_reg;
    logic [47:0] out_data_reg;
    logic        out_sing_reg;
    logic [15:0] sy;
    logic        sing;

    // whole pipe moves unless a result is held
    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;

    // threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= 15'd1;
        else if (cfg_wr_en)
            thr_reg <= cfg_wr_data;
    end

    // sum of the squares of m00 and m10
    always_comb
    begin
        sq_next.valid = s_tvalid;
        sq_next.m00   = s_tdata[15:0];
        sq_next.m10   = s_tdata[31:16];
        sq_next.m20   = s_tdata[47:32];
        sq_next.m21   = s_tdata[63:48];
        sq_next.m22   = s_tdata[79:64];
        sq_next.m11   = s_tdata[95:80];
        sq_next.m12   = s_tdata[111:96];
        sq_next.rem   = 32'(sq_next.m00 * sq_next.m00) + 32'(sq_next.m10 * sq_next.m10);
        sq_next.root  = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_reg <= '0;
        else if (adv)
            sq_reg <= sq_next;
    end

    assign sq_link[0] = sq_reg;

    // square-root cells
    for (genvar k = 0; k < SqrtSteps; k++)
    begin : g_sqrt
        eul_sqrt_cell #(.K(k)) u_sqrt (
            .clk  (clk),
            .rst_n(rst_n),
            .en   (adv),
            .din  (sq_link[k]),
            .dout (sq_link[k+1])
        );
    end

    // branch select and CORDIC operands
    always_comb
    begin
        sy            = sq_link[SqrtSteps].root[15:0];
        sing          = {1'b0, sy} < {2'b0, thr_reg};
        pitch_in_next = prerot(sq_link[SqrtSteps].valid, sing,
                               -OpW'(sq_link[SqrtSteps].m20), OpW'({1'b0, sy}));
        if (sing)
        begin
            roll_in_next = prerot(sq_link[SqrtSteps].valid, sing,
                                  -OpW'(sq_link[SqrtSteps].m12),
                                  OpW'(sq_link[SqrtSteps].m11));
            yaw_in_next  = prerot(sq_link[SqrtSteps].valid, sing, '0, '0);
        end
        else
        begin
            roll_in_next = prerot(sq_link[SqrtSteps].valid, sing,
                                  OpW'(sq_link[SqrtSteps].m21),
                                  OpW'(sq_link[SqrtSteps].m22));
            yaw_in_next  = prerot(sq_link[SqrtSteps].valid, sing,
                                  OpW'(sq_link[SqrtSteps].m10),
                                  OpW'(sq_link[SqrtSteps].m00));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            roll_in_reg  <= '0;
            pitch_in_reg <= '0;
            yaw_in_reg   <= '0;
        end
        else if (adv)
        begin
            roll_in_reg  <= roll_in_next;
            pitch_in_reg <= pitch_in_next;
            yaw_in_reg   <= yaw_in_next;
        end
    end

    // three rotation lanes
    eul_cordic_lane #(.CORDIC_STEPS(CORDIC_STEPS)) u_roll (
        .clk(clk), .rst_n(rst_n), .en(adv), .din(roll_in_reg), .dout(roll_out)
    );
    eul_cordic_lane #(.CORDIC_STEPS(CORDIC_STEPS)) u_pitch (
        .clk(clk), .rst_n(rst_n), .en(adv), .din(pitch_in_reg), .dout(pitch_out)
    );
    eul_cordic_lane #(.CORDIC_STEPS(CORDIC_STEPS)) u_yaw (
        .clk(clk), .rst_n(rst_n), .en(adv), .din(yaw_in_reg), .dout(yaw_out)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= pitch_out.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= {to_q313(yaw_out), to_q313(pitch_out), to_q313(roll_out)};
            out_sing_reg <= pitch_out.tag;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_sing_reg;

    // checks
    `EUL_ASSERT_NOW(a_sing_yaw_zero, m_tvalid && m_tuser[0], m_tdata[47:32] == 16'd0)
    `EUL_ASSERT_NOW(a_stall_blocks_input, m_tvalid && !m_tready, !s_tready)
    `EUL_ASSERT_NEXT(a_lanes_aligned, roll_out.valid != pitch_out.valid,
                     1'b0)

endmodule

>>> rtl/core/eul_sqrt_cell.sv
module eul_sqrt_cell import eul_pkg::*; #(
    parameter int K = 0
) (
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  sq_t  din,
    output sq_t  dout
);

    localparam logic [31:0] Bit = 32'(1) << (2 * (SqrtSteps - 1 - K));

    sq_t         dout_reg;
    sq_t         dout_next;
    logic [32:0] trial;

    // one result bit per cell
    always_comb
    begin
        dout_next = din;
        trial     = {1'b0, din.root} + {1'b0, Bit};
        if ({1'b0, din.rem} >= trial)
        begin
            dout_next.rem  = din.rem - trial[31:0];
            dout_next.root = (din.root >> 1) + Bit;
        end
        else
        begin
            dout_next.root = din.root >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dout_reg <= '0;
        else if (en)
            dout_reg <= dout_next;
    end

    assign dout = dout_reg;

endmodule

>>> rtl/core/eul_cordic_cell.sv
module eul_cordic_cell import eul_pkg::*; #(
    parameter int SHIFT = 0
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    en,
    input  cordic_t din,
    output cordic_t dout
);

    localparam logic signed [ZW-1:0] Atan = atan_q24(SHIFT);

    cordic_t               dout_reg;
    cordic_t               dout_next;
    logic signed [XyW-1:0] xs;
    logic signed [XyW-1:0] ys;

    // one micro-rotation driving y toward zero
    always_comb
    begin
        xs        = din.x >>> SHIFT;
        ys        = din.y >>> SHIFT;
        dout_next = din;
        if (!din.y[XyW-1])
        begin
            dout_next.x = din.x + ys;
            dout_next.y = din.y - xs;
            dout_next.z = din.z + Atan;
        end
        else
        begin
            dout_next.x = din.x - ys;
            dout_next.y = din.y + xs;
            dout_next.z = din.z - Atan;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dout_reg <= '0;
        else if (en)
            dout_reg <= dout_next;
    end

    assign dout = dout_reg;

endmodule

>>> rtl/core/eul_cordic_lane.sv
module eul_cordic_lane import eul_pkg::*; #(
    parameter int CORDIC_STEPS = CordicStepsDef
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    en,
    input  cordic_t din,
    output cordic_t dout
);

    cordic_t link [CORDIC_STEPS+1];

    assign link[0] = din;

    // row of micro-rotation cells
    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cell
        eul_cordic_cell #(.SHIFT(i)) u_cell (
            .clk  (clk),
            .rst_n(rst_n),
            .en   (en),
            .din  (link[i]),
            .dout (link[i+1])
        );
    end

    assign dout = link[CORDIC_STEPS];

endmodule
